FILE: design/vpse_pkg.sv
// shared types, constants and helpers for the vertex projection segment block
// no dependencies
package vpse_pkg;

    localparam int unsigned CoordW   = 24;
    localparam int unsigned TrigW    = 16;
    localparam int unsigned HalfW    = 12;
    localparam int unsigned ScreenW  = 16;
    localparam int unsigned SegNumW  = 10;
    localparam int unsigned RotShift = 14;
    localparam int unsigned ProdW    = CoordW + TrigW;
    localparam int unsigned RxW      = ProdW + 1 - RotShift;
    localparam int unsigned RzW      = RxW + 1;
    localparam int unsigned RyW      = CoordW + 1;
    localparam int unsigned NumW     = CoordW + 1 + RzW - 1;
    localparam int unsigned DenW     = RzW + 8;
    localparam int unsigned SumW     = NumW + 2;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned MaxNodesDefault = 1024;

    localparam logic signed [RzW-1:0] DepthMin = RzW'(512);

    localparam logic [CfgIdxW-1:0] RegSin   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegCos   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegCamY  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCamZ  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegFocal = 3'd4;
    localparam logic [CfgIdxW-1:0] RegHalfW = 3'd5;
    localparam logic [CfgIdxW-1:0] RegHalfH = 3'd6;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic signed [CoordW-1:0] vertex_z;
        logic                     vertex_ignored;
        logic                     first_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [ScreenW-1:0] seg_x0;
        logic signed [ScreenW-1:0] seg_y0;
        logic signed [ScreenW-1:0] seg_x1;
        logic signed [ScreenW-1:0] seg_y1;
        logic [SegNumW-1:0]        seg_number;
    } t_out_item;

    typedef struct packed {
        logic signed [TrigW-1:0]  sin_angle;
        logic signed [TrigW-1:0]  cos_angle;
        logic signed [CoordW-1:0] cam_y;
        logic signed [CoordW-1:0] cam_z;
        logic [CoordW-1:0]        focal_distance;
        logic [HalfW-1:0]         half_width;
        logic [HalfW-1:0]         half_height;
    } t_cfg;

    typedef struct packed {
        logic signed [RxW-1:0] rx;
        logic signed [RyW-1:0] ry;
        logic signed [RzW-1:0] rz;
        logic                  ignored;
        logic                  first;
    } t_rot_item;

    function automatic logic signed [ScreenW-1:0] sat16(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        hi = SumW'(32767);
        lo = -SumW'(32768);
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[ScreenW-1:0];
    endfunction

endpackage

FILE: design/vpse_front.sv
// front end: accepts vertices, rotates about y and adds the camera offset
// depends on vpse_pkg
module vpse_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  vpse_pkg::t_in_item   i_in_data,
    input  vpse_pkg::t_cfg       i_cfg,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output vpse_pkg::t_rot_item  o_q_data
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_PUSH} t_state;

    t_state r_state;
    vpse_pkg::t_in_item r_item;
    logic signed [vpse_pkg::ProdW-1:0] r_xc, r_zs, r_xs, r_zc;
    logic signed [vpse_pkg::ProdW:0] rx_sum, rz_sum;

    always_comb begin
        rx_sum = (vpse_pkg::ProdW+1)'(r_xc) - (vpse_pkg::ProdW+1)'(r_zs);
        rz_sum = (vpse_pkg::ProdW+1)'(r_xs) + (vpse_pkg::ProdW+1)'(r_zc);
        o_q_data.rx = rx_sum[vpse_pkg::ProdW:vpse_pkg::RotShift];
        o_q_data.rz = vpse_pkg::RzW'($signed(rz_sum[vpse_pkg::ProdW:vpse_pkg::RotShift]))
                    + vpse_pkg::RzW'(i_cfg.cam_z);
        o_q_data.ry = vpse_pkg::RyW'(r_item.vertex_y) + vpse_pkg::RyW'(i_cfg.cam_y);
        o_q_data.ignored = r_item.vertex_ignored;
        o_q_data.first   = r_item.first_vertex;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_q_push   = (r_state == S_PUSH) && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_xc    <= r_item.vertex_x * i_cfg.cos_angle;
                    r_zs    <= r_item.vertex_z * i_cfg.sin_angle;
                    r_xs    <= r_item.vertex_x * i_cfg.sin_angle;
                    r_zc    <= r_item.vertex_z * i_cfg.cos_angle;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/vpse_queue.sv
// two-entry queue between front and back
// depends on vpse_pkg
module vpse_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vpse_pkg::t_rot_item  i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output vpse_pkg::t_rot_item  o_data
);
    vpse_pkg::t_rot_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

FILE: design/vpse_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on vpse_pkg
module vpse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vpse_pkg::NumW-1:0]  i_num,
    input  logic [vpse_pkg::DenW-1:0]  i_den,
    output logic                       o_done,
    output logic [vpse_pkg::NumW-1:0]  o_quo
);
    localparam int unsigned CntW = $clog2(vpse_pkg::NumW);

    logic                       r_busy;
    logic                       r_done;
    logic [CntW-1:0]            r_cnt;
    logic [vpse_pkg::NumW-1:0]  r_num;
    logic [vpse_pkg::DenW:0]    r_rem;
    logic [vpse_pkg::DenW-1:0]  r_den;
    logic [vpse_pkg::DenW:0]    trial;
    logic                       ge;

    assign trial  = {r_rem[vpse_pkg::DenW-1:0], r_num[vpse_pkg::NumW-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
                r_num <= {r_num[vpse_pkg::NumW-2:0], ge};
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(vpse_pkg::NumW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: design/vpse_back.sv
// back end: perspective divide, saturation, previous point and segment output
// depends on vpse_pkg and vpse_div
module vpse_back #(
    parameter int unsigned MAX_NODES = vpse_pkg::MaxNodesDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  vpse_pkg::t_rot_item  i_q_data,
    output logic                 o_q_pop,
    input  vpse_pkg::t_cfg       i_cfg,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output vpse_pkg::t_out_item  o_out_data
);
    localparam int unsigned CntW = $clog2(MAX_NODES);
    localparam int unsigned StW  = (CntW > vpse_pkg::SegNumW) ? CntW : vpse_pkg::SegNumW;
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_NODES - 1);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    t_state r_state;
    vpse_pkg::t_rot_item r_it;
    logic r_start;
    logic r_prev_valid;
    logic signed [vpse_pkg::ScreenW-1:0] r_prev_x, r_prev_y;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] r_idx;
    logic r_pv;
    logic signed [vpse_pkg::NumW-1:0] r_nx, r_ny;
    logic r_out_valid;
    vpse_pkg::t_out_item r_out;

    logic [CntW-1:0] idx_now;
    logic [CntW-1:0] cnt_next;
    logic pv_now, pt_valid;
    logic [vpse_pkg::NumW-1:0] mag_x, mag_y, q_x, q_y;
    logic [vpse_pkg::DenW-1:0] den;
    logic done_x, done_y;
    logic signed [vpse_pkg::SumW-1:0] sum_x, sum_y, qs_x, qs_y;
    logic signed [vpse_pkg::ScreenW-1:0] sx, sy;
    logic emit, out_busy, out_load;
    logic [StW-1:0] start_w;

    assign idx_now  = i_q_data.first ? '0 : r_cnt;
    assign pv_now   = i_q_data.first ? 1'b0 : r_prev_valid;
    assign pt_valid = !i_q_data.ignored && (i_q_data.rz > vpse_pkg::DepthMin);
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    assign mag_x = r_nx[vpse_pkg::NumW-1] ? vpse_pkg::NumW'(-r_nx) : vpse_pkg::NumW'(r_nx);
    assign mag_y = r_ny[vpse_pkg::NumW-1] ? vpse_pkg::NumW'(-r_ny) : vpse_pkg::NumW'(r_ny);
    assign den   = {(vpse_pkg::DenW-8)'(r_it.rz), 8'd0};

    vpse_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(mag_x), .i_den(den), .o_done(done_x), .o_quo(q_x)
    );
    vpse_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(mag_y), .i_den(den), .o_done(done_y), .o_quo(q_y)
    );

    always_comb begin
        qs_x = r_nx[vpse_pkg::NumW-1] ? -$signed({2'b00, q_x}) : $signed({2'b00, q_x});
        qs_y = r_ny[vpse_pkg::NumW-1] ? -$signed({2'b00, q_y}) : $signed({2'b00, q_y});
        sum_x = qs_x + $signed({{(vpse_pkg::SumW-vpse_pkg::HalfW){1'b0}}, i_cfg.half_width});
        sum_y = $signed({{(vpse_pkg::SumW-vpse_pkg::HalfW){1'b0}}, i_cfg.half_height}) - qs_y;
        sx = vpse_pkg::sat16(sum_x);
        sy = vpse_pkg::sat16(sum_y);
        emit = r_pv && !((sx == r_prev_x) && (sy == r_prev_y));
        out_busy = r_out_valid && i_out_stall;
        out_load = (r_state == S_FIN) && emit && !out_busy;
        cnt_next = (r_idx < CntMax) ? (r_idx + CntW'(1)) : CntMax;
        start_w = StW'(r_idx) - StW'(r_idx != '0);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start      <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_it  <= i_q_data;
                        r_idx <= idx_now;
                        r_pv  <= pv_now;
                        if (pt_valid) begin
                            r_state <= S_MUL;
                        end else begin
                            r_prev_valid <= 1'b0;
                            r_cnt <= (idx_now < CntMax) ? (idx_now + CntW'(1)) : CntMax;
                        end
                    end
                end
                S_MUL: begin
                    r_nx    <= $signed({1'b0, i_cfg.focal_distance}) * r_it.rx;
                    r_ny    <= $signed({1'b0, i_cfg.focal_distance}) * r_it.ry;
                    r_start <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (done_x && done_y) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!(emit && out_busy)) begin
                        if (emit) begin
                            r_out.seg_x0     <= r_prev_x;
                            r_out.seg_y0     <= r_prev_y;
                            r_out.seg_x1     <= sx;
                            r_out.seg_y1     <= sy;
                            r_out.seg_number <= start_w[vpse_pkg::SegNumW-1:0];
                            r_out_valid      <= 1'b1;
                        end
                        r_prev_x     <= sx;
                        r_prev_y     <= sy;
                        r_prev_valid <= 1'b1;
                        r_cnt        <= cnt_next;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/vertex_project_segment_emit_top.sv
// top level of the vertex projection segment block: config registers, front, queue, back
// depends on vpse_pkg, vpse_front, vpse_queue, vpse_back
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// the front takes a new vertex only after pushing the last one to the queue; the
// back runs a drawable vertex through the 52-step divider and drops an ignored or
// too-near one while idle. the two-entry queue lets the front run ahead of the back.
// reset is synchronous and clears control state and config to defaults.
// a held output item only stalls the back when a new segment must be written.
module vertex_project_segment_emit_top #(
    parameter int unsigned MAX_NODES = vpse_pkg::MaxNodesDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  vpse_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output vpse_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [vpse_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [vpse_pkg::CoordW-1:0]      i_cfg_data
);
    vpse_pkg::t_cfg      r_cfg;
    vpse_pkg::t_rot_item push_data, pop_data;
    logic push, full, pop, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_angle      <= 16'sd0;
            r_cfg.cos_angle      <= 16'sd16384;
            r_cfg.cam_y          <= 24'sd0;
            r_cfg.cam_z          <= 24'sd768;
            r_cfg.focal_distance <= 24'd256;
            r_cfg.half_width     <= 12'd640;
            r_cfg.half_height    <= 12'd360;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vpse_pkg::RegSin:   r_cfg.sin_angle      <= i_cfg_data[vpse_pkg::TrigW-1:0];
                vpse_pkg::RegCos:   r_cfg.cos_angle      <= i_cfg_data[vpse_pkg::TrigW-1:0];
                vpse_pkg::RegCamY:  r_cfg.cam_y          <= i_cfg_data;
                vpse_pkg::RegCamZ:  r_cfg.cam_z          <= i_cfg_data;
                vpse_pkg::RegFocal: r_cfg.focal_distance <= i_cfg_data;
                vpse_pkg::RegHalfW: r_cfg.half_width     <= i_cfg_data[vpse_pkg::HalfW-1:0];
                vpse_pkg::RegHalfH: r_cfg.half_height    <= i_cfg_data[vpse_pkg::HalfW-1:0];
                default: ;
            endcase
        end
    end

    vpse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_cfg(r_cfg), .i_q_full(full), .o_q_push(push), .o_q_data(push_data)
    );

    vpse_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(push_data), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(pop_data)
    );

    vpse_back #(.MAX_NODES(MAX_NODES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(empty), .i_q_data(pop_data), .o_q_pop(pop),
        .i_cfg(r_cfg),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );
endmodule
